>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks, compiled away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: invariant");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/bpas_pkg.sv
// ---------------------------------------------------------------------------
// Block padding add/strip package
// Transfer types, configuration codes and sequencer states.
// ---------------------------------------------------------------------------
package bpas_pkg;

	localparam int APB_AW = 4;

	localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
	localparam logic [1:0] REG_PAD_SCHEME   = 2'd1;
	localparam logic [1:0] REG_STRIP_MODE   = 2'd2;

	localparam logic [5:0] BLOCK_LENGTH_RST = 6'd16;
	localparam logic [7:0] ISO_MARK         = 8'h80;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
		logic       in_empty;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_has_byte;
		logic       out_last;
		logic       pad_error;
	} out_item_t;

	typedef struct packed {
		logic [5:0] block_length;
		logic       pad_scheme;
		logic       strip_mode;
	} cfg_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} emit_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_PAD_BYTE,
		ST_PAD_COUNT,
		ST_PAD_FILL,
		ST_SPILL_RD,
		ST_SPILL_OUT,
		ST_PUSH,
		ST_TAIL_CHECK,
		ST_PKCS_RD,
		ST_PKCS_CHK,
		ST_ISO_RD,
		ST_ISO_CHK,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_MARK
	} state_t;

endpackage

>>> design/bpas_regs.sv
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style register file: block length, padding scheme, strip mode.
// ---------------------------------------------------------------------------
module bpas_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpas_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output bpas_pkg::cfg_t              cfg
);
	import bpas_pkg::*;

	logic [5:0] block_length_q;
	logic       pad_scheme_q;
	logic       strip_mode_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= BLOCK_LENGTH_RST;
			pad_scheme_q   <= 1'b0;
			strip_mode_q   <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BLOCK_LENGTH: block_length_q <= pwdata[5:0];
				REG_PAD_SCHEME:   pad_scheme_q   <= pwdata[0];
				REG_STRIP_MODE:   strip_mode_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BLOCK_LENGTH: prdata = {26'd0, block_length_q};
			REG_PAD_SCHEME:   prdata = {31'd0, pad_scheme_q};
			REG_STRIP_MODE:   prdata = {31'd0, strip_mode_q};
			default:          prdata = 32'd0;
		endcase
	end

	assign cfg = '{block_length: block_length_q, pad_scheme: pad_scheme_q,
		strip_mode: strip_mode_q};

endmodule

>>> design/bpas_tail_mem.sv
// ---------------------------------------------------------------------------
// Tail buffer memory
// Ring storage for the newest message bytes, one write and one registered read.
// ---------------------------------------------------------------------------
module bpas_tail_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/bpas_ctrl.sv
// ---------------------------------------------------------------------------
// Padding sequencer
// Walks one item at a time through pass-through, padding, spill and strip
// steps around a shared subtract/compare unit and the tail buffer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bpas_ctrl #(
	parameter int MAX_BLOCK = 32,
	parameter int AW        = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bpas_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpas_pkg::in_item_t in_item,
	input  logic               slot_free,
	output bpas_pkg::emit_t    emit,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [7:0]         mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  logic [7:0]         mem_rdata
);
	import bpas_pkg::*;

	localparam int            CW        = $clog2(MAX_BLOCK + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BLOCK - 1);
	localparam logic [CW-1:0] FULL      = CW'(MAX_BLOCK);
	localparam logic [CW-1:0] ONE       = CW'(1);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == LAST_ADDR) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? LAST_ADDR : p - 1'b1;
	endfunction

	state_t        state_q, state_d;
	logic [7:0]    byte_q, byte_d;
	logic          last_q, last_d;
	logic          has_q, has_d;
	logic          err_q, err_d;
	logic [AW-1:0] phase_q, phase_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] wr_q, wr_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] eff_b;
	logic [7:0]    alu_a, alu_b;
	logic [8:0]    alu_diff;
	logic          alu_borrow;
	logic          idx_last;

	always_comb begin
		if (cfg.block_length == '0) begin
			eff_b = ONE;
		end else if (cfg.block_length > 6'(MAX_BLOCK)) begin
			eff_b = FULL;
		end else begin
			eff_b = CW'(cfg.block_length);
		end
	end

	always_comb begin
		case (state_q)
			ST_PAD_COUNT: begin
				alu_a = 8'(eff_b);
				alu_b = 8'(phase_q);
			end
			ST_PKCS_CHK: begin
				alu_a = 8'(fill_q);
				alu_b = mem_rdata;
			end
			default: begin
				alu_a = 8'(phase_q);
				alu_b = 8'(eff_b);
			end
		endcase
	end

	assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
	assign alu_borrow = alu_diff[8];
	assign idx_last   = (idx_q + ONE) == cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			fill_q  <= '0;
			head_q  <= '0;
			wr_q    <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			fill_q  <= fill_d;
			head_q  <= head_d;
			wr_q    <= wr_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		last_q <= last_d;
		has_q  <= has_d;
		err_q  <= err_d;
		ptr_q  <= ptr_d;
		cnt_q  <= cnt_d;
		idx_q  <= idx_d;
	end

	always_comb begin
		state_d   = state_q;
		byte_d    = byte_q;
		last_d    = last_q;
		has_d     = has_q;
		err_d     = err_q;
		phase_d   = phase_q;
		fill_d    = fill_q;
		head_d    = head_q;
		wr_d      = wr_q;
		ptr_d     = ptr_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		in_ready  = 1'b0;
		emit      = '0;
		mem_we    = 1'b0;
		mem_waddr = wr_q;
		mem_wdata = byte_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (!in_item.in_empty || in_item.in_last)) begin
					byte_d = in_item.in_byte;
					last_d = in_item.in_last;
					has_d  = !in_item.in_empty;
					if (!cfg.strip_mode) begin
						state_d = ST_REDUCE;
					end else if (in_item.in_empty) begin
						state_d = ST_TAIL_CHECK;
					end else if (fill_q == FULL) begin
						state_d = ST_SPILL_RD;
					end else begin
						state_d = ST_PUSH;
					end
				end
			end
			ST_REDUCE: begin
				if (!alu_borrow) begin
					phase_d = AW'(alu_diff[7:0]);
				end else begin
					state_d = has_q ? ST_PAD_BYTE : ST_PAD_COUNT;
				end
			end
			ST_PAD_BYTE: begin
				emit.valid = 1'b1;
				emit.item  = '{out_byte: byte_q, out_has_byte: 1'b1, out_last: 1'b0,
					pad_error: 1'b0};
				if (slot_free) begin
					phase_d = ((CW'(phase_q) + ONE) == eff_b) ? '0 : phase_q + 1'b1;
					state_d = last_q ? ST_PAD_COUNT : ST_IDLE;
				end
			end
			ST_PAD_COUNT: begin
				cnt_d   = CW'(alu_diff[7:0]);
				idx_d   = '0;
				state_d = ST_PAD_FILL;
			end
			ST_PAD_FILL: begin
				emit.valid              = 1'b1;
				emit.item.out_has_byte  = 1'b1;
				emit.item.out_last      = idx_last;
				if (cfg.pad_scheme) begin
					emit.item.out_byte = (idx_q == '0) ? ISO_MARK : 8'h00;
				end else begin
					emit.item.out_byte = 8'(cnt_q);
				end
				if (slot_free) begin
					idx_d = idx_q + ONE;
					if (idx_last) begin
						fill_d  = '0;
						phase_d = '0;
						head_d  = '0;
						wr_d    = '0;
						state_d = ST_IDLE;
					end
				end
			end
			ST_SPILL_RD: begin
				mem_re    = 1'b1;
				mem_raddr = head_q;
				state_d   = ST_SPILL_OUT;
			end
			ST_SPILL_OUT: begin
				emit.valid = 1'b1;
				emit.item  = '{out_byte: mem_rdata, out_has_byte: 1'b1, out_last: 1'b0,
					pad_error: 1'b0};
				if (slot_free) begin
					head_d  = ptr_inc(head_q);
					fill_d  = fill_q - ONE;
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				mem_we  = 1'b1;
				wr_d    = ptr_inc(wr_q);
				fill_d  = fill_q + ONE;
				state_d = last_q ? ST_TAIL_CHECK : ST_IDLE;
			end
			ST_TAIL_CHECK: begin
				err_d = 1'b0;
				ptr_d = ptr_dec(wr_q);
				cnt_d = fill_q;
				if (fill_q == '0) begin
					err_d   = 1'b1;
					state_d = ST_MARK;
				end else begin
					state_d = cfg.pad_scheme ? ST_ISO_RD : ST_PKCS_RD;
				end
			end
			ST_PKCS_RD: begin
				mem_re  = 1'b1;
				state_d = ST_PKCS_CHK;
			end
			ST_PKCS_CHK: begin
				idx_d = '0;
				ptr_d = head_q;
				cnt_d = CW'(alu_diff[7:0]);
				if (alu_borrow) begin
					err_d   = 1'b1;
					state_d = ST_MARK;
				end else if (alu_diff[7:0] == 8'd0) begin
					state_d = ST_MARK;
				end else begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_ISO_RD: begin
				mem_re  = 1'b1;
				state_d = ST_ISO_CHK;
			end
			ST_ISO_CHK: begin
				cnt_d = cnt_q - ONE;
				if (mem_rdata == 8'h00) begin
					if (cnt_q == ONE) begin
						err_d   = 1'b1;
						state_d = ST_MARK;
					end else begin
						ptr_d   = ptr_dec(ptr_q);
						state_d = ST_ISO_RD;
					end
				end else if (cnt_q == ONE) begin
					state_d = ST_MARK;
				end else begin
					ptr_d   = head_q;
					idx_d   = '0;
					state_d = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: begin
				mem_re  = 1'b1;
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				emit.valid = 1'b1;
				emit.item  = '{out_byte: mem_rdata, out_has_byte: 1'b1, out_last: idx_last,
					pad_error: 1'b0};
				if (slot_free) begin
					ptr_d = ptr_inc(ptr_q);
					idx_d = idx_q + ONE;
					if (idx_last) begin
						fill_d  = '0;
						phase_d = '0;
						head_d  = '0;
						wr_d    = '0;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_MARK: begin
				emit.valid = 1'b1;
				emit.item  = '{out_byte: 8'h00, out_has_byte: 1'b0, out_last: 1'b1,
					pad_error: err_q};
				if (slot_free) begin
					fill_d  = '0;
					phase_d = '0;
					head_d  = '0;
					wr_d    = '0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= FULL)
	`ASSERT_IMPLIES(a_push_room, clk, arst_n, state_q == ST_PUSH, fill_q < FULL)
	`ASSERT_IMPLIES(a_scan_nonempty, clk, arst_n, state_q == ST_ISO_CHK, cnt_q != '0)
	`ASSERT_NEXT(a_last_ends, clk, arst_n, emit.valid && slot_free && emit.item.out_last, state_q == ST_IDLE)

endmodule

>>> design/block_padding_add_strip.sv
// ---------------------------------------------------------------------------
// Block padding add/strip
// PKCS#7 and ISO/IEC 7816-4 padder and unpadder for a byte stream.
// ---------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  cfg       in         psel/penable/...   paddr, pwdata, prdata
//  in        in         in_valid/in_ready  in_item  (in_byte, in_last, in_empty)
//  out       out        out_valid/out_ready out_item (out_byte, out_has_byte,
//                                                     out_last, pad_error)
//
//  Pad mode: a message byte passes ST_REDUCE, which subtracts block_length from
//  the carried phase until it borrows, then ST_PAD_BYTE; the end adds ST_PAD_COUNT
//  and ST_PAD_FILL per padding byte. Strip mode: a byte is pushed, the oldest held
//  byte first spilling out when full. The end reads the last byte (PKCS#7) or
//  scans back (ISO), then reads out kept bytes, all through the one read port.
//  Reset clears the configuration to its defaults and empties the tail buffer.
//  A stalled out_ready holds the sequencer at its next transfer; in_ready is high only when idle.
// ---------------------------------------------------------------------------
module block_padding_add_strip #(
	parameter int MAX_BLOCK = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpas_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bpas_pkg::in_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bpas_pkg::out_item_t         out_item
);
	import bpas_pkg::*;

	localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

	cfg_t          cfg;
	emit_t         emit;
	logic          slot_free;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic          out_valid_q;
	out_item_t     out_item_q;

	bpas_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpas_tail_mem #(
		.DEPTH (MAX_BLOCK),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bpas_ctrl #(
		.MAX_BLOCK (MAX_BLOCK),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.slot_free (slot_free),
		.emit      (emit),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && emit.valid) begin
			out_item_q <= emit.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Block padding add/strip testbench
// Drives byte messages through the padder/unpadder in PKCS#7 and ISO/IEC
// 7816-4 modes, pad and strip, over a range of block lengths. An in-bench
// padding predictor queues the expected output transfers, and every output
// transfer is compared against them field by field, under random source gaps
// and sink stalls.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpas_pkg::*;

	localparam int DEPTH      = 32;
	localparam int GAP_CYCLES = 64;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	in_item_t            in_item;
	logic                out_valid;
	logic                out_ready;
	out_item_t           out_item;

	logic [7:0]          held [DEPTH];
	int unsigned         held_fill;
	int unsigned         phase;
	int unsigned         spilled;
	logic [5:0]          cur_blen;
	logic                cur_iso;
	logic                cur_strip;
	out_item_t           pending_q[$];
	logic [7:0]          msg_q[$];
	int unsigned         errors;
	int unsigned         items_sent;
	int                  tx_idle_pct;
	int                  rx_stall_pct;

	block_padding_add_strip uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	always #5 clk = ~clk;

	function automatic int unsigned block_size();
		if (cur_blen == 6'd0) return 1;
		if (cur_blen > DEPTH) return DEPTH;
		return cur_blen;
	endfunction

	function automatic void push_result(logic [7:0] b, logic has, logic last, logic err);
		out_item_t r;
		r.out_byte     = b;
		r.out_has_byte = has;
		r.out_last     = last;
		r.pad_error    = err;
		pending_q.push_back(r);
	endfunction

	function automatic void end_message();
		held_fill = 0;
		phase     = 0;
		spilled   = 0;
	endfunction

	function automatic void predict_pad(logic has, logic [7:0] b, logic last);
		int unsigned bs;
		int unsigned cnt;
		bs    = block_size();
		phase = phase % bs;
		if (has) begin
			push_result(b, 1'b1, 1'b0, 1'b0);
			phase = (phase + 1) % bs;
		end
		if (!last) return;
		cnt = bs - phase;
		for (int unsigned i = 0; i < cnt; i++) begin
			if (cur_iso)
				push_result((i == 0) ? ISO_MARK : 8'h00, 1'b1, i + 1 == cnt, 1'b0);
			else
				push_result(cnt[7:0], 1'b1, i + 1 == cnt, 1'b0);
		end
		end_message();
	endfunction

	function automatic void predict_strip(logic has, logic [7:0] b, logic last);
		int unsigned keep;
		int unsigned n;
		int unsigned j;
		logic        bad;
		keep = 0;
		bad  = 1'b0;
		if (has) begin
			if (held_fill >= DEPTH) begin
				push_result(held[0], 1'b1, 1'b0, 1'b0);
				for (int i = 0; i < DEPTH - 1; i++)
					held[i] = held[i + 1];
				held_fill = DEPTH - 1;
				spilled   = 1;
			end
			held[held_fill] = b;
			held_fill++;
		end
		if (!last) return;
		if (held_fill == 0) begin
			bad = 1'b1;
		end else if (!cur_iso) begin
			n = held[held_fill - 1];
			if (n > held_fill) bad = 1'b1;
			else keep = held_fill - n;
		end else begin
			j = held_fill;
			while (j > 0 && held[j - 1] == 8'h00) j--;
			if (j == 0) bad = 1'b1;
			else keep = j - 1;
		end
		if (bad || keep == 0) begin
			push_result(8'h00, 1'b0, 1'b1, bad);
		end else begin
			for (int unsigned i = 0; i < keep; i++)
				push_result(held[i], 1'b1, i + 1 == keep, 1'b0);
		end
		end_message();
	endfunction

	function automatic void predict_item(in_item_t it);
		if (it.in_empty && !it.in_last) return;
		if (cur_strip) predict_strip(!it.in_empty, it.in_byte, it.in_last);
		else predict_pad(!it.in_empty, it.in_byte, it.in_last);
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected transfer, expected none, actual byte=%h has=%b last=%b err=%b",
				$time, got.out_byte, got.out_has_byte, got.out_last, got.pad_error);
			errors++;
			return;
		end
		want = pending_q.pop_front();
		if (got.out_byte !== want.out_byte || got.out_has_byte !== want.out_has_byte ||
				got.out_last !== want.out_last || got.pad_error !== want.pad_error) begin
			$display("%0t: mismatch, expected byte=%h has=%b last=%b err=%b, actual byte=%h has=%b last=%b err=%b",
				$time, want.out_byte, want.out_has_byte, want.out_last, want.pad_error,
				got.out_byte, got.out_has_byte, got.out_last, got.pad_error);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) predict_item(in_item);
			if (out_valid && out_ready) check_result(out_item);
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	task automatic send_item(logic [7:0] b, logic last, logic empty);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{in_byte: b, in_last: last, in_empty: empty};
		do @(posedge clk); while (!in_ready);
		if (!(empty && !last)) items_sent++;
	endtask

	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (GAP_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_BLOCK_LENGTH: cur_blen  = val[5:0];
			REG_PAD_SCHEME:   cur_iso   = val[0];
			REG_STRIP_MODE:   cur_strip = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [5:0] blen, logic iso, logic strip);
		settle_idle();
		reg_write(REG_BLOCK_LENGTH, {26'd0, blen});
		reg_write(REG_PAD_SCHEME, {31'd0, iso});
		reg_write(REG_STRIP_MODE, {31'd0, strip});
	endtask

	task automatic send_message(bit end_empty);
		for (int i = 0; i < msg_q.size(); i++) begin
			if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b1);
			send_item(msg_q[i], !end_empty && i == msg_q.size() - 1, 1'b0);
		end
		if (end_empty || msg_q.size() == 0) send_item(8'($urandom), 1'b1, 1'b1);
	endtask

	task automatic build_message();
		int unsigned len;
		int unsigned bs;
		int unsigned padn;
		bit          zeros;
		msg_q.delete();
		len   = ($urandom_range(7) == 0) ? $urandom_range(0, 45) : $urandom_range(0, 10);
		zeros = cur_strip && ($urandom_range(7) == 0);
		repeat (len) msg_q.push_back(zeros ? 8'h00 : 8'($urandom));
		if (cur_strip && !zeros && $urandom_range(4) != 0) begin
			bs   = block_size();
			padn = bs - (len % bs);
			for (int unsigned i = 0; i < padn; i++) begin
				if (cur_iso) msg_q.push_back((i == 0) ? ISO_MARK : 8'h00);
				else msg_q.push_back(padn[7:0]);
			end
		end
	endtask

	task automatic random_config();
		logic [5:0] blen;
		case ($urandom_range(7))
			0: blen = 6'd0;
			1: blen = 6'd1;
			2: blen = 6'd32;
			3: blen = 6'd63;
			default: blen = 6'($urandom_range(1, 32));
		endcase
		set_config(blen, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic test_pad_schemes();
		set_config(6'd16, 1'b0, 1'b0);
		send_item(8'($urandom), 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		set_config(6'd16, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'($urandom), 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'($urandom), 1'b1, 1'b1);
	endtask

	task automatic test_block_length_range();
		set_config(6'd0, 1'b0, 1'b0);
		send_item(8'hA5, 1'b1, 1'b0);
		set_config(6'd63, 1'b1, 1'b0);
		send_item(8'($urandom), 1'b1, 1'b1);
		set_config(6'd32, 1'b0, 1'b0);
		repeat (3) send_item(8'($urandom), 1'b0, 1'b0);
		settle_idle();
		reg_write(REG_BLOCK_LENGTH, 32'd2);
		send_item(8'($urandom), 1'b1, 1'b1);
	endtask

	task automatic test_strip_pkcs7();
		set_config(6'd16, 1'b0, 1'b1);
		send_item(8'($urandom), 1'b1, 1'b1);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'hAA, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h05, 1'b1, 1'b0);
	endtask

	task automatic test_strip_iso();
		set_config(6'd16, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h12, 1'b0, 1'b0);
		send_item(ISO_MARK, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b0);
	endtask

	task automatic test_random_traffic(int tx_pct, int rx_pct, int target);
		int unsigned start;
		settle_idle();
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		start        = items_sent;
		while (items_sent - start < target) begin
			if ($urandom_range(99) < 30) random_config();
			build_message();
			send_message($urandom_range(3) == 0);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		in_item      = '0;
		out_ready    = 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		errors       = 0;
		items_sent   = 0;
		cur_blen     = BLOCK_LENGTH_RST;
		cur_iso      = 1'b0;
		cur_strip    = 1'b0;
		end_message();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_pad_schemes();
		test_block_length_range();
		test_strip_pkcs7();
		test_strip_iso();
		test_random_traffic(0, 0, 30);
		test_random_traffic(49, 0, 30);
		test_random_traffic(0, 49, 30);
		test_random_traffic(28, 28, 30);

		settle_idle();
		if (errors == 0 && pending_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
